>>> rtl/vn_pkg.sv
// Package for the four-component vector normaliser: widths, pipeline payload types.
`default_nettype none
package vn_pkg;

    // Component width, two's complement Q1.(W-1).
    localparam int W         = 16;
    localparam int NLANE     = 4;
    localparam int SQ_BITS   = 2 * W;
    localparam int SUM_BITS  = 2 * W + 1;
    localparam int ROOT_BITS = W + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int DREM_BITS = ROOT_BITS + 1;
    localparam int IN_DATA_BITS  = ((NLANE * W + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = NLANE * W + ROOT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_RAW_BITS;

    // Payload carried along the square-root cells.
    typedef struct packed {
        logic [NLANE-1:0]            neg;
        logic [NLANE-1:0][W-1:0]     mag;
        logic [RAD_BITS-1:0]         rad;
        logic [REM_BITS-1:0]         rem;
        logic [ROOT_BITS-1:0]        root;
    } t_sq_data;

    // Payload carried along the division cells.
    typedef struct packed {
        logic [NLANE-1:0]                neg;
        logic [NLANE-1:0]                feed;
        logic [NLANE-1:0][DREM_BITS-1:0] rem;
        logic [NLANE-1:0][W-1:0]         quo;
        logic [ROOT_BITS-1:0]            len;
        logic                            zero;
    } t_dv_data;

endpackage
`default_nettype wire

>>> rtl/vn_sqrt_cell.sv
// One digit cell of the pipelined square root: settles one root bit per request.
`default_nettype none
module vn_sqrt_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  vn_pkg::t_sq_data  i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output vn_pkg::t_sq_data  o_data
);

    logic                            r_valid;
    vn_pkg::t_sq_data                r_data;
    vn_pkg::t_sq_data                n_data;
    logic [vn_pkg::REM_BITS-1:0]     w_part;
    logic [vn_pkg::REM_BITS-1:0]     w_trial;

    // The cell takes a new request whenever it is empty or its result moves on.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        w_part  = {i_data.rem[vn_pkg::REM_BITS-3:0],
                   i_data.rad[vn_pkg::RAD_BITS-1 -: 2]};
        w_trial = {i_data.root, 2'b01};
        n_data  = i_data;
        n_data.rad = {i_data.rad[vn_pkg::RAD_BITS-3:0], 2'b00};
        if (w_part >= w_trial) begin
            n_data.rem  = w_part - w_trial;
            n_data.root = {i_data.root[vn_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
            n_data.rem  = w_part;
            n_data.root = {i_data.root[vn_pkg::ROOT_BITS-2:0], 1'b0};
        end
    end

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/vn_div_cell.sv
// One digit cell of the pipelined divider: one quotient bit for each of the four lanes.
`default_nettype none
module vn_div_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  vn_pkg::t_dv_data  i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output vn_pkg::t_dv_data  o_data
);

    logic                             r_valid;
    vn_pkg::t_dv_data                 r_data;
    vn_pkg::t_dv_data                 n_data;
    logic [vn_pkg::DREM_BITS-1:0]     w_part [vn_pkg::NLANE];
    logic [vn_pkg::DREM_BITS-1:0]     w_len;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Restoring step on each lane against the shared length.
    always_comb begin
        w_len  = {1'b0, i_data.len};
        n_data = i_data;
        n_data.feed = '0;
        for (int k = 0; k < vn_pkg::NLANE; k++) begin
            w_part[k] = {i_data.rem[k][vn_pkg::DREM_BITS-2:0], i_data.feed[k]};
            if (w_part[k] >= w_len) begin
                n_data.rem[k] = w_part[k] - w_len;
                n_data.quo[k] = {i_data.quo[k][vn_pkg::W-2:0], 1'b1};
            end else begin
                n_data.rem[k] = w_part[k];
                n_data.quo[k] = {i_data.quo[k][vn_pkg::W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/vec4_normalize.sv
// Path from request to result: the front stage, one square-root cell per root bit,
// one divider cell per quotient bit and the output register, each a register stage.
// Throughput: one vector per cycle; every stage advances whenever its successor is
// empty or moving, so bubbles close up under back-pressure.
// Reset (synchronous, active low) clears all stage valid bits; no payload is cleared.
// Top level of the four-component vector normaliser.
`default_nettype none
module vec4_normalize (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // comp_x, comp_y, comp_z, comp_w from the lowest bit up.
    input  wire  [vn_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // unit_x, unit_y, unit_z, unit_w, length, zero padding from the lowest bit up.
    output logic [vn_pkg::OUT_DATA_BITS-1:0]  o_m_tdata,
    // zero_vector.
    output logic [0:0]                        o_m_tuser
);

    localparam int NSQ = vn_pkg::ROOT_BITS;
    localparam int NDV = vn_pkg::W;

    // Front stage: magnitudes and squares.
    logic                                        r_f_valid;
    logic [vn_pkg::NLANE-1:0]                    r_f_neg;
    logic [vn_pkg::NLANE-1:0][vn_pkg::W-1:0]     r_f_mag;
    logic [vn_pkg::NLANE-1:0][vn_pkg::SQ_BITS-1:0] r_f_sq;
    logic [vn_pkg::NLANE-1:0]                    n_f_neg;
    logic [vn_pkg::NLANE-1:0][vn_pkg::W-1:0]     n_f_mag;
    logic                                        w_f_ready;

    // Cell chains.
    logic              w_sq_valid [NSQ+1];
    logic              w_sq_ready [NSQ+1];
    vn_pkg::t_sq_data  w_sq_data  [NSQ+1];
    logic              w_dv_valid [NDV+1];
    logic              w_dv_ready [NDV+1];
    vn_pkg::t_dv_data  w_dv_data  [NDV+1];

    logic [vn_pkg::SUM_BITS-1:0]                 w_sum;
    vn_pkg::t_dv_data                            w_dv_first;

    // Output register.
    logic                                        r_o_valid;
    logic [vn_pkg::NLANE-1:0][vn_pkg::W-1:0]     r_o_unit;
    logic [vn_pkg::ROOT_BITS-1:0]                r_o_len;
    logic                                        r_o_zero;
    logic [vn_pkg::NLANE-1:0][vn_pkg::W-1:0]     n_o_unit;
    logic                                        w_o_ready;

    // Sign and magnitude of each component.
    always_comb begin
        for (int k = 0; k < vn_pkg::NLANE; k++) begin
            n_f_neg[k] = i_s_tdata[k*vn_pkg::W + vn_pkg::W - 1];
            n_f_mag[k] = n_f_neg[k] ? vn_pkg::W'(-i_s_tdata[k*vn_pkg::W +: vn_pkg::W])
                                    : i_s_tdata[k*vn_pkg::W +: vn_pkg::W];
        end
    end

    assign w_f_ready  = !r_f_valid || w_sq_ready[0];
    assign o_s_tready = w_f_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_f_ready) begin
            r_f_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_ready && i_s_tvalid) begin
            r_f_neg <= n_f_neg;
            r_f_mag <= n_f_mag;
            for (int k = 0; k < vn_pkg::NLANE; k++) begin
                r_f_sq[k] <= n_f_mag[k] * n_f_mag[k];
            end
        end
    end

    // Exact sum of squares loads the first root cell.
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < vn_pkg::NLANE; k++) begin
            w_sum = w_sum + {1'b0, r_f_sq[k]};
        end
        w_sq_data[0].neg  = r_f_neg;
        w_sq_data[0].mag  = r_f_mag;
        w_sq_data[0].rad  = {1'b0, w_sum};
        w_sq_data[0].rem  = '0;
        w_sq_data[0].root = '0;
    end
    assign w_sq_valid[0] = r_f_valid;

    // Square-root chain.
    for (genvar g = 0; g < NSQ; g++) begin : g_sq
        vn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_valid[g]),
            .o_ready (w_sq_ready[g]),
            .i_data  (w_sq_data[g]),
            .o_valid (w_sq_valid[g+1]),
            .i_ready (w_sq_ready[g+1]),
            .o_data  (w_sq_data[g+1])
        );
    end

    // Hand over to the divider: each magnitude is at most the length, so the
    // top part of the shifted dividend already lies below it.
    always_comb begin
        w_dv_first.neg  = w_sq_data[NSQ].neg;
        w_dv_first.len  = w_sq_data[NSQ].root;
        w_dv_first.zero = (w_sq_data[NSQ].root == '0);
        for (int k = 0; k < vn_pkg::NLANE; k++) begin
            w_dv_first.feed[k] = w_sq_data[NSQ].mag[k][0];
            w_dv_first.rem[k]  = {{(vn_pkg::DREM_BITS-vn_pkg::W+1){1'b0}},
                                  w_sq_data[NSQ].mag[k][vn_pkg::W-1:1]};
            w_dv_first.quo[k]  = '0;
        end
    end
    assign w_dv_valid[0]   = w_sq_valid[NSQ];
    assign w_dv_data[0]    = w_dv_first;
    assign w_sq_ready[NSQ] = w_dv_ready[0];

    // Division chain.
    for (genvar g = 0; g < NDV; g++) begin : g_dv
        vn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv_valid[g]),
            .o_ready (w_dv_ready[g]),
            .i_data  (w_dv_data[g]),
            .o_valid (w_dv_valid[g+1]),
            .i_ready (w_dv_ready[g+1]),
            .o_data  (w_dv_data[g+1])
        );
    end

    // Sign, saturation and the zero-vector case.
    always_comb begin
        for (int k = 0; k < vn_pkg::NLANE; k++) begin
            if (w_dv_data[NDV].zero) begin
                n_o_unit[k] = '0;
            end else if (w_dv_data[NDV].neg[k]) begin
                n_o_unit[k] = vn_pkg::W'(-w_dv_data[NDV].quo[k]);
            end else if (w_dv_data[NDV].quo[k][vn_pkg::W-1]) begin
                n_o_unit[k] = {1'b0, {(vn_pkg::W-1){1'b1}}};
            end else begin
                n_o_unit[k] = w_dv_data[NDV].quo[k];
            end
        end
    end

    assign w_o_ready       = !r_o_valid || i_m_tready;
    assign w_dv_ready[NDV] = w_o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_ready) begin
            r_o_valid <= w_dv_valid[NDV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_ready && w_dv_valid[NDV]) begin
            r_o_unit <= n_o_unit;
            r_o_len  <= w_dv_data[NDV].len;
            r_o_zero <= w_dv_data[NDV].zero;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{vn_pkg::OUT_PAD_BITS{1'b0}}, r_o_len, r_o_unit};
    assign o_m_tuser  = r_o_zero;

    // A zero vector always reports a zero length.
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_zero) |-> (r_o_len == '0))
        else $error("zero vector with non-zero length");

    // A non-zero vector never reports a zero length.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_zero) |-> (r_o_len != '0))
        else $error("non-zero vector with zero length");

    // A stalled result stays in the output register.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_m_tready) |=> (r_o_valid && $stable(r_o_len)))
        else $error("stalled result lost");

    // Reset empties the output stage.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !r_o_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

>>> tb/vec4_normalize_test.sv
// Self-checking testbench for the four-component vector normaliser stream block.
module vec4_normalize_test;

    typedef struct packed {
        logic [vn_pkg::W-1:0] w;
        logic [vn_pkg::W-1:0] z;
        logic [vn_pkg::W-1:0] y;
        logic [vn_pkg::W-1:0] x;
    } t_vec;

    typedef struct {
        logic [vn_pkg::NLANE-1:0][vn_pkg::W-1:0] unit;
        logic [vn_pkg::ROOT_BITS-1:0]            len;
        logic                                    zero;
    } t_norm;

    localparam int IDLE_LIMIT = 2000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic [vn_pkg::IN_DATA_BITS-1:0]  i_s_tdata = '0;
    logic                             i_m_tready = 1'b0;
    logic                             o_s_tready;
    logic                             o_m_tvalid;
    logic [vn_pkg::OUT_DATA_BITS-1:0] o_m_tdata;
    logic [0:0]                       o_m_tuser;

    // Handshake flags captured at the rising edge for the driver.
    logic o_s_tready_q = 1'b0;
    logic o_m_tvalid_q = 1'b0;

    t_vec  pending_vecs[$];
    t_norm expected_norms[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    drain_hold = 0;
    int    send_wait = 0;
    int    recv_wait = 0;
    string unit_names [vn_pkg::NLANE] = '{"unit_x", "unit_y", "unit_z", "unit_w"};

    vec4_normalize DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Bitwise integer square root, floor.
    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Expected length and unit vector for one request.
    function automatic t_norm normalise(t_vec v);
        t_norm r;
        logic [vn_pkg::W-1:0] c [vn_pkg::NLANE];
        logic [63:0] mag [vn_pkg::NLANE];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic [63:0] one;
        c[0] = v.x; c[1] = v.y; c[2] = v.z; c[3] = v.w;
        one = 64'd1 << (vn_pkg::W - 1);
        sum = 0;
        for (int i = 0; i < vn_pkg::NLANE; i++) begin
            mag[i] = c[i][vn_pkg::W-1] ? ((64'd1 << vn_pkg::W) - c[i]) : c[i];
            sum = sum + mag[i] * mag[i];
        end
        r.zero = (sum == 0);
        len = isqrt(sum);
        r.len = len[vn_pkg::ROOT_BITS-1:0];
        for (int i = 0; i < vn_pkg::NLANE; i++) begin
            if (r.zero) begin
                r.unit[i] = '0;
            end else begin
                q = (mag[i] * one) / len;
                if (c[i][vn_pkg::W-1]) begin
                    if (q > one) q = one;
                    r.unit[i] = vn_pkg::W'((64'd1 << vn_pkg::W) - q);
                end else begin
                    if (q > one - 1) q = one - 1;
                    r.unit[i] = q[vn_pkg::W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [vn_pkg::W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return vn_pkg::W'(32768 + $urandom_range(0, 3));
            1: return vn_pkg::W'(32767 - $urandom_range(0, 3));
            2: return vn_pkg::W'($urandom_range(0, 7) - 4);
            3: return vn_pkg::W'($urandom_range(0, 255) - 128);
            default: return vn_pkg::W'($urandom);
        endcase
    endfunction

    task automatic add_vec(int x, int y, int z, int w);
        t_vec v;
        v.x = vn_pkg::W'(x); v.y = vn_pkg::W'(y);
        v.z = vn_pkg::W'(z); v.w = vn_pkg::W'(w);
        pending_vecs.push_back(v);
    endtask

    // Driver: presents queued requests and takes results, each after a random gap.
    always @(negedge i_clk) begin
        int send_gap;
        int recv_gap;
        if (i_rst_n) begin
            // Sender: the slot is free when idle or when the last request was taken.
            if (!i_s_tvalid || o_s_tready_q) begin
                if (i_s_tvalid) send_gap = $urandom_range(0, 5);
                else send_gap = send_wait;
                if (send_gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    send_wait <= send_gap - 1;
                end else if (pending_vecs.size() > 0
                             && !(drain_hold && expected_norms.size() > 0)) begin
                    i_s_tdata <= pending_vecs.pop_front();
                    i_s_tvalid <= 1'b1;
                    send_wait <= 0;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            // Receiver: a fresh gap is drawn after every result taken.
            if (!i_m_tready || o_m_tvalid_q) begin
                if (i_m_tready) recv_gap = $urandom_range(0, 5);
                else recv_gap = recv_wait;
                if (recv_gap > 0) begin
                    i_m_tready <= 1'b0;
                    recv_wait <= recv_gap - 1;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        end
    end

    // Monitor: predicts on accepted requests and checks accepted results.
    always @(posedge i_clk) begin
        t_norm e;
        o_s_tready_q <= i_s_tvalid && o_s_tready;
        o_m_tvalid_q <= o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                expected_norms.push_back(
                    normalise(t_vec'(i_s_tdata[vn_pkg::NLANE*vn_pkg::W-1:0])));
            if (o_m_tvalid && i_m_tready) begin
                if (expected_norms.size() == 0) begin
                    $error("unexpected result %h", o_m_tdata);
                    errors++;
                end else begin
                    e = expected_norms.pop_front();
                    for (int i = 0; i < vn_pkg::NLANE; i++)
                        if (o_m_tdata[i*vn_pkg::W +: vn_pkg::W] !== e.unit[i]) begin
                            $error("%s expected %h actual %h", unit_names[i], e.unit[i],
                                   o_m_tdata[i*vn_pkg::W +: vn_pkg::W]);
                            errors++;
                        end
                    if (o_m_tdata[vn_pkg::NLANE*vn_pkg::W +: vn_pkg::ROOT_BITS] !== e.len)
                    begin
                        $error("length expected %h actual %h", e.len,
                               o_m_tdata[vn_pkg::NLANE*vn_pkg::W +: vn_pkg::ROOT_BITS]);
                        errors++;
                    end
                    if (o_m_tuser[0] !== e.zero) begin
                        $error("zero_vector expected %b actual %b", e.zero, o_m_tuser[0]);
                        errors++;
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("vec4_normalize_test failed");
                $finish;
            end
        end
    end

    initial begin
        // Directed part: zero, extremes, exact unit length and saturation.
        add_vec(0, 0, 0, 0);
        add_vec(-32768, -32768, -32768, -32768);
        add_vec(32767, 32767, 32767, 32767);
        add_vec(-32768, 0, 0, 0);
        add_vec(0, 32767, 0, 0);
        add_vec(0, 0, 1, 0);
        add_vec(0, 0, 0, -1);
        add_vec(16384, 0, 0, 0);
        add_vec(-16384, 0, 0, 0);
        add_vec(3, 4, 0, 0);
        add_vec(1, 1, 1, 1);
        add_vec(-1, -1, -1, -1);
        add_vec(32767, -32768, 32767, -32768);
        add_vec(1, 0, 0, 32767);
        add_vec(-21846, 21845, -12345, 5);
        add_vec(-1, 0, 0, 0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 1800; k++) begin
            t_vec v;
            v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = rand_comp();
            if ($urandom_range(0, 19) == 0) v = '0;
            pending_vecs.push_back(v);
            // Halfway through, hold the sender until the pipeline has emptied.
            if (k == 900) begin
                while (pending_vecs.size() > 0) @(posedge i_clk);
                drain_hold = 1;
                while (expected_norms.size() > 0 || i_s_tvalid) @(posedge i_clk);
                drain_hold = 0;
            end
        end
        while (pending_vecs.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_norms.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_norms.size() == 0) begin
            $display("vec4_normalize_test passed");
        end else begin
            $display("vec4_normalize_test failed");
        end
        $finish;
    end
endmodule
